// ===== rtl/alpha_sprite_overlay_unit_defines.svh =====
// Assertion macros shared by the sprite overlay RTL.
`ifndef ALPHA_SPRITE_OVERLAY_UNIT_DEFINES_SVH
`define ALPHA_SPRITE_OVERLAY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASO_ASSERT(lbl, prop, msg)
`define ASO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/aso_pkg.sv =====
// Types and constants for the sprite overlay unit.
package aso_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BLEND = 1'b1;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        op;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  ch0;
    logic [7:0]  ch1;
    logic [7:0]  ch2;
    logic [7:0]  alpha;
  } in_t;

  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic [7:0]  out_ch0;
    logic [7:0]  out_ch1;
    logic [7:0]  out_ch2;
  } out_t;

  // Stored texel word: alpha in the top byte, ch0 in the bottom byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] ch2;
    logic [7:0] ch1;
    logic [7:0] ch0;
  } texel_t;

  typedef struct packed {
    logic signed [12:0] left;
    logic signed [12:0] top;
    logic [7:0]         width;
    logic [7:0]         height;
  } cfg_t;

endpackage

// ===== rtl/aso_cfg_regs.sv =====
// APB register file holding the sprite window placement and size.
module aso_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aso_pkg::CFG_AW-1:0]  paddr,
  input  logic [aso_pkg::CFG_DW-1:0]  pwdata,
  output logic [aso_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output aso_pkg::cfg_t               cfg
);

  aso_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = aso_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  // Write the addressed register in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        aso_pkg::REG_LEFT:   cfg.left   <= pwdata[12:0];
        aso_pkg::REG_TOP:    cfg.top    <= pwdata[12:0];
        aso_pkg::REG_WIDTH:  cfg.width  <= pwdata[7:0];
        aso_pkg::REG_HEIGHT: cfg.height <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back, sign-extending the offsets
  always_comb begin
    case (idx)
      aso_pkg::REG_LEFT:   prdata = {{19{cfg.left[12]}}, cfg.left};
      aso_pkg::REG_TOP:    prdata = {{19{cfg.top[12]}}, cfg.top};
      aso_pkg::REG_WIDTH:  prdata = {24'd0, cfg.width};
      aso_pkg::REG_HEIGHT: prdata = {24'd0, cfg.height};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== rtl/aso_sprite_mem.sv =====
// Sprite texel memory: one write port, one read port with registered data.
module aso_sprite_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  aso_pkg::texel_t       wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output aso_pkg::texel_t       rdata
);

  aso_pkg::texel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data while the next stage is stalled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/aso_mix.sv =====
// One colour channel of the blend: weighted sum, then exact divide by 255.
module aso_mix (
  input  logic       clk,
  input  logic       en_sum,
  input  logic       en_div,
  input  logic [7:0] bg,
  input  logic [7:0] fg,
  input  logic [7:0] a,
  output logic [7:0] res
);

  logic [15:0] sum;
  logic [15:0] sum_next;
  logic [15:0] quo;

  // bg*(255-a) + fg*a never exceeds 255*255
  assign sum_next = 16'({8'd0, bg} * {8'd0, ~a}) + 16'({8'd0, fg} * {8'd0, a});

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum <= sum_next;
    end
  end

  // floor(x/255) = (x + 1 + (x >> 8)) >> 8 over the whole 16-bit range used
  assign quo = sum + 16'd1 + {8'd0, sum[15:8]};

  always_ff @(posedge clk) begin
    if (en_div) begin
      res <= quo[15:8];
    end
  end

endmodule

// ===== rtl/alpha_sprite_overlay_unit.sv =====
// Sprite overlay unit: four-stage pipeline of decode, texel read, weighted sum, divide.
// A blend result is valid after passing the read, sum and divide registers; an output stall can hold it.
// Throughput: one unstalled item per cycle, load or blend, set by the single memory access per cycle.
// Load items write the sprite memory as they leave the decode stage and give no result.
// Reset clears pipeline valid flags and window registers; sprite memory is not cleared.
`include "alpha_sprite_overlay_unit_defines.svh"
module alpha_sprite_overlay_unit #(
  parameter int SPRITE_MAX_W = 128,
  parameter int SPRITE_MAX_H = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  aso_pkg::in_t                src_item,
  output logic                        dst_valid,
  input  logic                        dst_stall,
  output aso_pkg::out_t               dst_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aso_pkg::CFG_AW-1:0]  paddr,
  input  logic [aso_pkg::CFG_DW-1:0]  pwdata,
  output logic [aso_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int DEPTH = SPRITE_MAX_W * SPRITE_MAX_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  aso_pkg::cfg_t   cfg;
  aso_pkg::in_t    s0;
  logic            v0, v1, v2, v3;
  logic            rdy0, rdy1, rdy2, rdy3;
  logic            s0_load;

  logic signed [13:0] fx, fy;
  logic [10:0]        w_eff, h_eff;
  logic               in_win;
  logic               ld_ok;
  logic [AW-1:0]      blend_addr, load_addr;
  logic               mem_we, mem_re;
  aso_pkg::texel_t    texel;
  aso_pkg::texel_t    texel_eff;

  logic [11:0]     s1_col, s1_row, s2_col, s2_row;
  logic [7:0]      s1_ch0, s1_ch1, s1_ch2;
  logic            s1_win;
  logic [7:0]      a_eff;
  logic [11:0]     s3_col, s3_row;
  logic [7:0]      s3_ch0, s3_ch1, s3_ch2;

  aso_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage readiness: each stage takes a new item when empty or draining
  assign rdy3    = !v3 || !dst_stall;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign s0_load = (s0.op == aso_pkg::OP_LOAD);
  assign rdy0    = !v0 || s0_load || rdy1;
  assign src_stall = !rdy0;

  // Decode stage: register the item
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0 <= src_item;
    end
  end

  // Window test and sprite address for a blend item
  always_comb begin
    w_eff = (11'(cfg.width) > 11'(SPRITE_MAX_W)) ? 11'(SPRITE_MAX_W) : 11'(cfg.width);
    h_eff = (11'(cfg.height) > 11'(SPRITE_MAX_H)) ? 11'(SPRITE_MAX_H) : 11'(cfg.height);
    fx = $signed({2'b00, s0.col}) - $signed({cfg.left[12], cfg.left});
    fy = $signed({2'b00, s0.row}) - $signed({cfg.top[12], cfg.top});
    in_win = !fx[13] && !fy[13] && (fx[12:0] < {2'b00, w_eff})
             && (fy[12:0] < {2'b00, h_eff});
    blend_addr = in_win ? AW'(fy[12:0]) * AW'(SPRITE_MAX_W) + AW'(fx[12:0]) : '0;
  end

  // Address for a load item, dropped when outside the sprite store
  assign ld_ok = ({1'b0, s0.col} < 13'(SPRITE_MAX_W)) && ({1'b0, s0.row} < 13'(SPRITE_MAX_H));
  assign load_addr = AW'(s0.row) * AW'(SPRITE_MAX_W) + AW'(s0.col);

  assign mem_we = v0 && s0_load && ld_ok;
  assign mem_re = v0 && !s0_load && rdy1;

  aso_sprite_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_addr),
    .wdata ({s0.alpha, s0.ch2, s0.ch1, s0.ch0}),
    .re    (mem_re),
    .raddr (blend_addr),
    .rdata (texel)
  );

  // Read stage: carry the background pixel beside the texel read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0 && !s0_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_col <= s0.col;
      s1_row <= s0.row;
      s1_ch0 <= s0.ch0;
      s1_ch1 <= s0.ch1;
      s1_ch2 <= s0.ch2;
      s1_win <= in_win;
    end
  end

  // Outside the window a zero texel passes the pixel unchanged
  assign texel_eff = s1_win ? texel : '0;
  assign a_eff     = texel_eff.alpha;

  // Sum stage and divide stage bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_col <= s1_col;
      s2_row <= s1_row;
    end
    if (rdy3) begin
      s3_col <= s2_col;
      s3_row <= s2_row;
    end
  end

  aso_mix u_mix0 (
    .clk    (clk),
    .en_sum (rdy2),
    .en_div (rdy3),
    .bg     (s1_ch0),
    .fg     (texel_eff.ch0),
    .a      (a_eff),
    .res    (s3_ch0)
  );

  aso_mix u_mix1 (
    .clk    (clk),
    .en_sum (rdy2),
    .en_div (rdy3),
    .bg     (s1_ch1),
    .fg     (texel_eff.ch1),
    .a      (a_eff),
    .res    (s3_ch1)
  );

  aso_mix u_mix2 (
    .clk    (clk),
    .en_sum (rdy2),
    .en_div (rdy3),
    .bg     (s1_ch2),
    .fg     (texel_eff.ch2),
    .a      (a_eff),
    .res    (s3_ch2)
  );

  // Assemble the output item
  assign dst_item  = aso_pkg::out_t'{out_col: s3_col, out_row: s3_row,
                                     out_ch0: s3_ch0, out_ch1: s3_ch1, out_ch2: s3_ch2};
  assign dst_valid = v3;

  // Checks
  `ASO_ASSERT(a_mem_one_access, !(mem_we && mem_re), "memory read and write in one cycle")
  `ASO_ASSERT(a_sum_holds, (v2 && v3 && dst_stall) |=> v2, "blend item lost under stall")
  `ASO_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !dst_valid, "result valid after reset")

endmodule

// ===== tb/alpha_sprite_overlay_unit_tb.sv =====
// Self-checking testbench for the sprite overlay unit: pixel predictor, item drivers, checker.
module alpha_sprite_overlay_unit_tb;

  localparam int SPRITE_W      = 128;
  localparam int SPRITE_H      = 128;
  localparam int SPRITE_TEXELS = SPRITE_W * SPRITE_H;
  localparam int HALF_PERIOD   = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;

  // Sprite store, window registers and the queue of composited pixels still due
  class pixel_scoreboard;
    aso_pkg::texel_t    sprite_mem [SPRITE_TEXELS];
    bit                 texel_written [SPRITE_TEXELS];
    logic signed [12:0] win_left   = '0;
    logic signed [12:0] win_top    = '0;
    logic [7:0]         win_width  = '0;
    logic [7:0]         win_height = '0;
    aso_pkg::out_t      expected_pixels [$];
    int                 mismatches = 0;

    function void write_reg(aso_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        aso_pkg::REG_LEFT:   win_left   = val[12:0];
        aso_pkg::REG_TOP:    win_top    = val[12:0];
        aso_pkg::REG_WIDTH:  win_width  = val[7:0];
        aso_pkg::REG_HEIGHT: win_height = val[7:0];
        default: ;
      endcase
    endfunction

    // Window size in use, clipped to the sprite store
    function int span(logic [7:0] size, int limit);
      return (int'(size) > limit) ? limit : int'(size);
    endfunction

    // Texel index under a background pixel, or -1 outside the window
    function int texel_under(logic [11:0] col, logic [11:0] row);
      int fx;
      int fy;
      fx = int'(col) - int'(win_left);
      fy = int'(row) - int'(win_top);
      if (fx < 0 || fy < 0 || fx >= span(win_width, SPRITE_W) ||
          fy >= span(win_height, SPRITE_H)) begin
        return -1;
      end
      return fy * SPRITE_W + fx;
    endfunction

    function logic [7:0] blend_channel(logic [7:0] bg, logic [7:0] fg, logic [7:0] a);
      logic [15:0] acc;
      acc = bg * (8'd255 - a) + fg * a;
      return 8'(acc / 16'd255);
    endfunction

    function int outstanding();
      return expected_pixels.size();
    endfunction

    // Store a texel, or work out the composited pixel for a blend item
    function void note_input(aso_pkg::in_t it);
      aso_pkg::out_t   px;
      aso_pkg::texel_t t;
      int              idx;
      if (it.op == aso_pkg::OP_LOAD) begin
        if (int'(it.col) < SPRITE_W && int'(it.row) < SPRITE_H) begin
          idx = int'(it.row) * SPRITE_W + int'(it.col);
          sprite_mem[idx]    = aso_pkg::texel_t'{alpha: it.alpha, ch2: it.ch2,
                                                 ch1: it.ch1, ch0: it.ch0};
          texel_written[idx] = 1'b1;
        end
        return;
      end
      px.out_col = it.col;
      px.out_row = it.row;
      px.out_ch0 = it.ch0;
      px.out_ch1 = it.ch1;
      px.out_ch2 = it.ch2;
      idx = texel_under(it.col, it.row);
      if (idx >= 0) begin
        t = sprite_mem[idx];
        px.out_ch0 = blend_channel(it.ch0, t.ch0, t.alpha);
        px.out_ch1 = blend_channel(it.ch1, t.ch1, t.alpha);
        px.out_ch2 = blend_channel(it.ch2, t.ch2, t.alpha);
      end
      expected_pixels.insert(expected_pixels.size(), px);
    endfunction

    // Compare one output item with the oldest pixel due
    function void check_result(aso_pkg::out_t got);
      aso_pkg::out_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected pixel: col %0d row %0d ch %h %h %h",
                   got.out_col, got.out_row, got.out_ch0, got.out_ch1, got.out_ch2);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got.out_col !== want.out_col || got.out_row !== want.out_row ||
          got.out_ch0 !== want.out_ch0 || got.out_ch1 !== want.out_ch1 ||
          got.out_ch2 !== want.out_ch2) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: want col %0d row %0d ch %h %h %h, got col %0d row %0d ch %h %h %h",
                   want.out_col, want.out_row, want.out_ch0, want.out_ch1, want.out_ch2,
                   got.out_col, got.out_row, got.out_ch0, got.out_ch1, got.out_ch2);
        end
      end
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        src_valid = 1'b0;
  logic                        src_stall;
  aso_pkg::in_t                src_item  = '0;
  logic                        dst_valid;
  logic                        dst_stall = 1'b0;
  aso_pkg::out_t               dst_item;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [aso_pkg::CFG_AW-1:0]  paddr     = '0;
  logic [aso_pkg::CFG_DW-1:0]  pwdata    = '0;
  logic [aso_pkg::CFG_DW-1:0]  prdata;
  logic                        pready;

  int                  idle_pct    = 0;
  int                  stall_pct   = 0;
  bit                  hold_active = 1'b0;
  int                  cycle_count = 0;
  event                hold_off_ev;
  pixel_scoreboard     sb = new();

  alpha_sprite_overlay_unit #(
    .SPRITE_MAX_W(SPRITE_W),
    .SPRITE_MAX_H(SPRITE_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item (src_item),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_item (dst_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("alpha_sprite_overlay_unit_tb: errors");
      $finish;
    end
  end

  // Stall the output at random, or throughout a hold-off
  always @(negedge clk) begin
    dst_stall <= hold_active || ($urandom_range(99) < stall_pct);
  end

  // Check every item taken from the output
  always @(posedge clk) begin
    if (!rst && dst_valid && !dst_stall) begin
      sb.check_result(dst_item);
    end
  end

  // Hold the output off for a long stretch so the pipeline fills and stalls its input
  initial forever begin
    @(hold_off_ev);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  function automatic aso_pkg::in_t make_item(logic op, int col, int row,
                                             int c0, int c1, int c2, int a);
    return aso_pkg::in_t'{op: op, col: 12'(col), row: 12'(row),
                          ch0: 8'(c0), ch1: 8'(c1), ch2: 8'(c2), alpha: 8'(a)};
  endfunction

  // Texel load with random colour, opacity now and then at its extremes
  function automatic aso_pkg::in_t random_texel(logic [11:0] col, logic [11:0] row);
    aso_pkg::in_t it;
    it = make_item(aso_pkg::OP_LOAD, int'(col), int'(row),
                   int'($urandom_range(255)), int'($urandom_range(255)),
                   int'($urandom_range(255)), int'($urandom_range(255)));
    case ($urandom_range(9))
      0: it.alpha = 8'h00;
      1: it.alpha = 8'hFF;
      default: ;
    endcase
    return it;
  endfunction

  // Offer one item after a random gap; return at the falling edge after it is taken
  task automatic send_item(aso_pkg::in_t it);
    while ($urandom_range(99) < idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    do @(posedge clk); while (src_stall);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Blend a pixel, loading the texel beneath it first if it was never written
  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    int idx;
    idx = sb.texel_under(col, row);
    if (idx >= 0 && !sb.texel_written[idx]) begin
      send_item(random_texel(12'(idx % SPRITE_W), 12'(idx / SPRITE_W)));
    end
    send_item(make_item(aso_pkg::OP_BLEND, int'(col), int'(row),
                        int'($urandom_range(255)), int'($urandom_range(255)),
                        int'($urandom_range(255)), int'($urandom_range(255))));
  endtask

  task automatic random_item();
    int pick;
    int off_c;
    int off_r;
    int c;
    int r;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // texel load, now and then outside the sprite store
      if ($urandom_range(3) == 0) begin
        send_item(random_texel(12'($urandom), 12'($urandom)));
      end else begin
        send_item(random_texel(12'($urandom_range(SPRITE_W - 1)),
                               12'($urandom_range(SPRITE_H - 1))));
      end
    end else begin
      // mostly around the window and its edges, the rest anywhere
      off_c = $urandom_range(sb.span(sb.win_width, SPRITE_W) + 3);
      off_r = $urandom_range(sb.span(sb.win_height, SPRITE_H) + 3);
      c = int'(sb.win_left) + off_c - 2;
      r = int'(sb.win_top) + off_r - 2;
      if (pick >= 80 || c < 0 || c > 4095) c = $urandom_range(4095);
      if (pick >= 80 || r < 0 || r > 4095) r = $urandom_range(4095);
      send_pixel(12'(c), 12'(r));
    end
  endtask

  // Register write: setup cycle, then access cycle; psel stays high between writes
  task automatic write_reg(aso_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_window(int left, int top, int width, int height);
    write_reg(aso_pkg::REG_LEFT, 32'(left));
    write_reg(aso_pkg::REG_TOP, 32'(top));
    write_reg(aso_pkg::REG_WIDTH, 32'(width));
    write_reg(aso_pkg::REG_HEIGHT, 32'(height));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and wait until every pixel due has come out and the pipeline is quiet
  task automatic drain();
    src_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int left, int top, int width, int height,
                           int src_idle, int dst_idle, int count, bit squeeze);
    drain();
    set_window(left, top, width, height);
    idle_pct  = src_idle;
    stall_pct = dst_idle;
    if (squeeze) -> hold_off_ev;
    repeat (count) random_item();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset window is empty: pixels pass untouched
    send_item(make_item(aso_pkg::OP_BLEND, 0, 0, 8'h00, 8'hFF, 8'h5A, 8'hFF));
    send_item(make_item(aso_pkg::OP_BLEND, 4095, 4095, 8'hFF, 8'h00, 8'hA5, 8'h00));
    drain();

    // directed: small window at the origin
    set_window(0, 0, 4, 4);
    send_item(make_item(aso_pkg::OP_LOAD, 0, 1, 11, 22, 33, 200));
    // out of range: would alias onto the texel just loaded
    send_item(make_item(aso_pkg::OP_LOAD, 128, 0, 99, 99, 99, 255));
    send_item(make_item(aso_pkg::OP_LOAD, 0, 0, 255, 255, 255, 0));
    // out of range: would wrap onto the origin texel
    send_item(make_item(aso_pkg::OP_LOAD, 0, 128, 0, 0, 0, 255));
    send_item(make_item(aso_pkg::OP_LOAD, 4095, 4095, 1, 2, 3, 4));
    send_item(make_item(aso_pkg::OP_LOAD, 1, 0, 255, 0, 170, 255));
    send_item(make_item(aso_pkg::OP_LOAD, 2, 0, 85, 170, 255, 128));
    send_item(make_item(aso_pkg::OP_LOAD, 3, 3, 0, 255, 0, 1));
    // zero alpha leaves the pixel as it is; then a partly opaque texel
    send_item(make_item(aso_pkg::OP_BLEND, 0, 0, 18, 52, 86, 0));
    send_item(make_item(aso_pkg::OP_BLEND, 0, 1, 255, 255, 255, 255));
    // full opacity gives the texel colour; then half and near-zero opacity
    send_item(make_item(aso_pkg::OP_BLEND, 1, 0, 0, 0, 0, 0));
    send_item(make_item(aso_pkg::OP_BLEND, 2, 0, 255, 0, 255, 255));
    send_item(make_item(aso_pkg::OP_BLEND, 3, 3, 255, 255, 255, 0));
    // just past the right and bottom edges
    send_item(make_item(aso_pkg::OP_BLEND, 4, 0, 7, 8, 9, 10));
    send_item(make_item(aso_pkg::OP_BLEND, 0, 4, 10, 9, 8, 7));
    send_item(make_item(aso_pkg::OP_BLEND, 4095, 4095, 0, 0, 0, 255));
    // blend straight after a load of the same texel, then after an overwrite
    send_item(make_item(aso_pkg::OP_LOAD, 1, 1, 200, 100, 50, 255));
    send_item(make_item(aso_pkg::OP_BLEND, 1, 1, 0, 128, 255, 0));
    send_item(make_item(aso_pkg::OP_LOAD, 1, 1, 1, 2, 3, 77));
    send_item(make_item(aso_pkg::OP_BLEND, 1, 1, 250, 5, 128, 33));
    repeat (60) random_item();

    // window off the left and top of the frame
    run_phase(-4096, -4096, 128, 128, 73, 0, 100, 1'b0);
    // window reduced to the last pixel of the frame
    run_phase(4095, 4095, 128, 128, 0, 73, 100, 1'b0);
    // oversized window, partly off the frame
    run_phase(-60, -30, 255, 200, 21, 21, 130, 1'b0);
    // single column under a long output hold-off
    run_phase(1000, 2000, 1, 128, 0, 0, 100, 1'b1);
    // zero height: every pixel passes
    run_phase(37, 5, 128, 0, 73, 0, 80, 1'b0);
    // clipped at the right and bottom of the frame
    run_phase(3990, 4000, 128, 128, 0, 73, 120, 1'b0);
    run_phase(0, 0, 16, 16, 21, 21, 120, 1'b0);

    drain();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("alpha_sprite_overlay_unit_tb: clean");
    end else begin
      $display("alpha_sprite_overlay_unit_tb: errors");
    end
    $finish;
  end

endmodule
